[rtl/byte_store_with_crc16_core_defines.svh]
// Assertion macros for the byte store with CRC-16 engine.
`ifndef BYTE_STORE_WITH_CRC16_CORE_DEFINES_SVH
`define BYTE_STORE_WITH_CRC16_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property checked at every rising edge outside reset.
`define BSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Overlapping implication checked at every rising edge outside reset.
`define BSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define BSC_ASSERT(lbl, prop, msg)
`define BSC_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

[rtl/bsc_pkg.sv]
// Shared types, constants and the CRC byte update for the byte store.
package bsc_pkg;

    localparam int          DEFAULT_MEM_DEPTH = 256;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [7:0]  LENGTH_RESET      = 8'd236;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_CRC   = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FIN  = 4'b0010,
        ST_CRC  = 4'b0100,
        ST_CLR  = 4'b1000
    } state_t;

    // Reflected CRC-16 over one byte, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/byte_store_with_crc16_core.sv]
// Byte store with a CRC-16 engine: top level.
//
//  channel  | dir | signals                                        | role
//  ---------+-----+------------------------------------------------+----------------------------
//  s_       | in  | s_valid s_ready s_action s_address s_write_data| one action per transfer
//  m_       | out | m_valid m_ready m_read_data m_crc_value m_in_range | one result per action
//  cfg_     | in  | cfg_valid cfg_ready cfg_data                   | active_length register
//
// Steps: read and write pass from idle to fin; clear walks the usable entries in clr,
// one zero written per cycle; crc walks them in crc, one memory read
// per byte through the single read port of the store.
// Entries carry a valid flag, set on write and dropped at reset; an entry whose
// flag is low reads as zero, so reset needs no clearing pass.
// Reset: synchronous, active low; store reads all zero, active_length is 236.
// Stalls: the result sits in an output register; the next item is taken while
// it waits, and that item holds in its final state until the register frees.
`include "byte_store_with_crc16_core_defines.svh"

module byte_store_with_crc16_core #(
    parameter int MEM_DEPTH = bsc_pkg::DEFAULT_MEM_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_address,
    input  logic [7:0]  s_write_data,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [15:0] m_crc_value,
    output logic        m_in_range
);
    import bsc_pkg::*;

    localparam int          AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [8:0]  DEPTH_LEN = 9'(MEM_DEPTH);

    // configuration register
    logic [7:0] active_length_reg;

    // usable length, never beyond the store depth
    logic [8:0] len;

    // engine control
    state_t      state_reg, state_next;
    action_t     act_reg, act_next;
    logic        in_range_reg, in_range_next;
    logic [15:0] crc_reg, crc_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic        pend_reg, pend_next;

    // per-entry valid flags; a low flag reads as zero
    logic [MEM_DEPTH-1:0] vld_reg, vld_next;

    // byte store, one write and one registered read port
    logic [7:0]    mem [MEM_DEPTH];
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]    mem_wd;
    logic [7:0]    mem_rd_reg;
    logic          vld_rd_reg;
    logic [7:0]    rd_byte;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_read_data_reg, m_read_data_next;
    logic [15:0] m_crc_value_reg, m_crc_value_next;
    logic        m_in_range_reg, m_in_range_next;

    logic s_xfer;
    logic s_in_range;
    logic out_free;

    assign cfg_ready = 1'b1;
    assign len = ({1'b0, active_length_reg} < DEPTH_LEN) ? {1'b0, active_length_reg}
                                                           : DEPTH_LEN;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_xfer     = s_valid && s_ready;
    assign s_in_range = ({1'b0, s_address} < len);
    assign out_free   = !m_valid_reg || m_ready;
    assign rd_byte    = vld_rd_reg ? mem_rd_reg : 8'd0;

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_crc_value = m_crc_value_reg;
    assign m_in_range  = m_in_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_length_reg <= LENGTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            active_length_reg <= cfg_data;
        end
    end

    // Engine: idle takes an item; clr and crc walk the store; fin hands the result over.
    always_comb begin
        state_next       = state_reg;
        act_next         = act_reg;
        in_range_next    = in_range_reg;
        crc_next         = crc_reg;
        cnt_next         = cnt_reg;
        pend_next        = 1'b0;
        vld_next         = vld_reg;
        mem_we           = 1'b0;
        mem_wa           = s_address[AW-1:0];
        mem_wd           = s_write_data;
        mem_re           = 1'b0;
        mem_ra           = s_address[AW-1:0];
        m_valid_next     = m_valid_reg && !m_ready;
        m_read_data_next = m_read_data_reg;
        m_crc_value_next = m_crc_value_reg;
        m_in_range_next  = m_in_range_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    act_next      = action_t'(s_action);
                    in_range_next = s_in_range;
                    crc_next      = CRC_INIT;
                    cnt_next      = 9'd0;
                    state_next    = ST_FIN;
                    case (action_t'(s_action))
                        ACT_READ: begin
                            mem_re = s_in_range;
                        end
                        ACT_WRITE: begin
                            if (s_in_range) begin
                                mem_we                       = 1'b1;
                                vld_next[s_address[AW-1:0]] = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            state_next = ST_CLR;
                        end
                        ACT_CRC: begin
                            state_next = ST_CRC;
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_CLR: begin
                // zero one usable entry per cycle
                if (cnt_reg < len) begin
                    mem_we   = 1'b1;
                    mem_wa   = cnt_reg[AW-1:0];
                    mem_wd   = 8'd0;
                    cnt_next = cnt_reg + 9'd1;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_CRC: begin
                // fold the byte read last cycle, issue the next read
                if (pend_reg) begin
                    crc_next = crc_byte(crc_reg, rd_byte);
                end
                if (cnt_reg < len) begin
                    mem_re    = 1'b1;
                    mem_ra    = cnt_reg[AW-1:0];
                    cnt_next  = cnt_reg + 9'd1;
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_read_data_next = (act_reg == ACT_READ && in_range_reg) ? rd_byte : 8'd0;
                    m_crc_value_next = (act_reg == ACT_CRC) ? crc_reg : 16'd0;
                    m_in_range_next  = in_range_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg         <= act_next;
        in_range_reg    <= in_range_next;
        crc_reg         <= crc_next;
        cnt_reg         <= cnt_next;
        m_read_data_reg <= m_read_data_next;
        m_crc_value_reg <= m_crc_value_next;
        m_in_range_reg  <= m_in_range_next;
    end

    // store array and its registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            mem_rd_reg <= mem[mem_ra];
            vld_rd_reg <= vld_reg[mem_ra];
        end
    end

    `BSC_ASSERT_IMP(a_busy_after_xfer, s_xfer, ##1 !s_ready, "engine took an item but stayed idle")
    `BSC_ASSERT_IMP(a_cnt_bound, state_reg == ST_CRC, cnt_reg <= len, "crc walk ran past length")
    `BSC_ASSERT_IMP(a_pend_src, pend_reg, $past(mem_re), "crc fold without a preceding read")
    `BSC_ASSERT_IMP(a_out_load, $rose(m_valid_reg), $past(state_reg) == ST_FIN, "result without fin")

endmodule
